// ===== design/atte_pkg.sv =====
// Package for the ANSI text terminal engine: geometry constants, byte codes,
// parser states and the shared memory request struct. No dependencies.
package atte_pkg;

	localparam int MaxRows    = 32;
	localparam int MaxColumns = 128;
	localparam int TitleLimit = 250;
	localparam int RowW   = 5;
	localparam int ColW   = 7;
	localparam int AddrW  = RowW + ColW;
	localparam int CellW  = 11;

	localparam logic [7:0] CH_ESC  = 8'd27;
	localparam logic [7:0] CH_BEL  = 8'd7;
	localparam logic [7:0] CH_CR   = 8'd13;
	localparam logic [7:0] CH_LF   = 8'd10;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_RBR  = 8'h5D;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_FOUR = 8'h34;
	localparam logic [7:0] CH_H    = 8'h48;
	localparam logic [7:0] CH_J    = 8'h4A;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [0:0] OP_PUT  = 1'b0;
	localparam logic [0:0] OP_READ = 1'b1;

	localparam logic [0:0] REG_ROWS = 1'b0;
	localparam logic [0:0] REG_COLS = 1'b1;

	typedef enum logic [2:0] {
		SQ_NONE  = 3'd0,
		SQ_START = 3'd1,
		SQ_CSI   = 3'd2,
		SQ_OSC   = 3'd3,
		SQ_SEMI  = 3'd4,
		SQ_TITLE = 3'd5
	} seq_t;

	// Memory request from the controller to the cell store
	typedef struct packed {
		logic             wr_en;
		logic [AddrW-1:0] wr_addr;
		logic [CellW-1:0] wr_data;
		logic             rd_en;
		logic [AddrW-1:0] rd_addr;
	} mem_req_t;

endpackage

// ===== design/ansi_text_terminal_engine_core.sv =====
// Top level of the ANSI text terminal engine: controller plus cell store.
// Depends on atte_pkg, atte_ctrl, atte_cell_ram.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  in       | in_valid / in_ready    | operation, byte_in, read_row, read_column
//  out      | out_valid / out_ready  | cell fields, cursor, title, in_sequence
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An ordinary byte or a sequence byte that starts no sweep goes from idle to the
// output state, a read through the read state first. A line feed at the bottom
// row walks the active area through the single store port pair, as an erase
// walks its range of cells. After reset a clearing pass writes spaces to all
// 4096 cells; no item is taken meanwhile, configuration writes are. The result
// register frees the input side: one more item is taken while a result waits,
// and its own result holds in the output stage until the waiting beat is taken.
module ansi_text_terminal_engine_core
	import atte_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic [7:0] byte_in,
	input  logic [4:0] read_row,
	input  logic [6:0] read_column,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] cell_character,
	output logic       cell_bold,
	output logic       cell_italic,
	output logic       cell_underline,
	output logic [4:0] cursor_row_out,
	output logic [6:0] cursor_column_out,
	output logic       title_valid,
	output logic [7:0] title_byte,
	output logic       title_end,
	output logic       in_sequence
);

	mem_req_t         req;
	logic [CellW-1:0] rd_data;

	// parser, cursor and sweep sequencer
	atte_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .operation, .byte_in, .read_row,
		.read_column, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .req,
		.rd_data, .out_valid, .out_ready, .cell_character, .cell_bold,
		.cell_italic, .cell_underline, .cursor_row_out, .cursor_column_out,
		.title_valid, .title_byte, .title_end, .in_sequence
	);

	// character cells, one beat per cycle
	atte_cell_ram u_ram (
		.clk, .req, .rd_data
	);

endmodule

// ===== design/atte_cell_ram.sv =====
// Cell store: 4096 x 11 synchronous RAM, one write and one registered read.
// Depends on atte_pkg.
module atte_cell_ram
	import atte_pkg::*;
(
	input  logic             clk,
	input  mem_req_t         req,
	output logic [CellW-1:0] rd_data
);

	logic [CellW-1:0] mem [MaxRows*MaxColumns];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

// ===== design/atte_ctrl.sv =====
// Controller: escape parser, cursor, clearing pass, scroll and erase sweeps.
// Depends on atte_pkg; drives atte_cell_ram through mem_req_t.
module atte_ctrl
	import atte_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             operation,
	input  logic [7:0]       byte_in,
	input  logic [4:0]       read_row,
	input  logic [6:0]       read_column,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [7:0]       cfg_data,
	output mem_req_t         req,
	input  logic [CellW-1:0] rd_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       cell_character,
	output logic             cell_bold,
	output logic             cell_italic,
	output logic             cell_underline,
	output logic [4:0]       cursor_row_out,
	output logic [6:0]       cursor_column_out,
	output logic             title_valid,
	output logic [7:0]       title_byte,
	output logic             title_end,
	output logic             in_sequence
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_SCRL  = 6'b001000,
		ST_FILL  = 6'b010000,
		ST_OUT   = 6'b100000
	} st_t;

	st_t              st_q;
	logic [5:0]       rows_q;
	logic [7:0]       cols_q;
	logic [RowW-1:0]  crow_q;
	logic [ColW-1:0]  ccol_q;
	seq_t             seq_q;
	logic [2:0]       marks_q;
	logic [7:0]       num0_q, num1_q;
	logic [1:0]       nidx_q, seen_q;
	logic [7:0]       farg_q;
	logic [7:0]       tlen_q;
	logic [AddrW-1:0] clr_q;
	// sweep position: row/col walk, and row-major limit as (row,col)
	logic [RowW-1:0]  wr_q;
	logic [ColW-1:0]  wc_q;
	logic [RowW-1:0]  er_q;
	logic [ColW-1:0]  ec_q;
	logic             rd_pend_q;
	logic             is_read_q;
	// title outcome of the item in flight
	logic             tvalid_q;
	logic [7:0]       tbyte_q;
	logic             tend_q;

	// clamped area
	logic [RowW-1:0] last_row;
	logic [ColW-1:0] last_col;
	always_comb begin
		if (rows_q == 6'd0) last_row = '0;
		else if (rows_q > 6'(MaxRows)) last_row = RowW'(MaxRows - 1);
		else last_row = RowW'(rows_q - 6'd1);
		if (cols_q == 8'd0) last_col = '0;
		else if (cols_q > 8'(MaxColumns)) last_col = ColW'(MaxColumns - 1);
		else last_col = ColW'(cols_q - 8'd1);
	end

	// cursor clamped into area at item start
	logic [RowW-1:0] crow_c;
	logic [ColW-1:0] ccol_c;
	assign crow_c = (crow_q > last_row) ? last_row : crow_q;
	assign ccol_c = (ccol_q > last_col) ? last_col : ccol_q;

	logic [2:0] blank_m;
	assign blank_m = marks_q;

	function automatic logic [7:0] sat10(input logic [7:0] n, input logic [7:0] b);
		logic [11:0] v;
		begin
			v = {4'd0, n} * 12'd10 + {8'd0, b[3:0]};
			sat10 = (v > 12'd255) ? 8'd255 : v[7:0];
		end
	endfunction

	function automatic logic [7:0] place(input logic [7:0] n, input logic seen,
		input logic [7:0] lim);
		logic [7:0] v;
		begin
			v = seen ? n : 8'd1;
			if (v != 8'd0) v = v - 8'd1;
			place = (v > lim) ? lim : v;
		end
	endfunction

	logic is_letter, is_digit;
	assign is_letter = (byte_in >= 8'h41 && byte_in <= 8'h5A) ||
		(byte_in >= 8'h61 && byte_in <= 8'h7A);
	assign is_digit = byte_in >= 8'h30 && byte_in <= 8'h39;

	logic accept;
	assign in_ready  = (st_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = (st_q == ST_IDLE) || (st_q == ST_CLEAR);

	logic title_take, title_stop;
	assign title_stop = operation == OP_PUT && seq_q == SQ_TITLE && byte_in == CH_BEL;
	assign title_take = operation == OP_PUT && seq_q == SQ_TITLE && byte_in != CH_BEL &&
		tlen_q < 8'(TitleLimit);

	// cursor and next state of an accepted item
	st_t             st_nx;
	logic [RowW-1:0] crow_nx;
	logic [ColW-1:0] ccol_nx;
	always_comb begin
		st_nx   = ST_OUT;
		crow_nx = crow_c;
		ccol_nx = ccol_c;
		if (operation == OP_READ) begin
			st_nx = ST_READ;
		end else begin
			case (seq_q)
				SQ_NONE: begin
					if (byte_in == CH_CR) ccol_nx = '0;
					else if (byte_in == CH_LF || (byte_in != CH_ESC && ccol_c == last_col)) begin
						ccol_nx = '0;
						if (crow_c == last_row) st_nx = (last_row == '0) ? ST_FILL : ST_SCRL;
						else crow_nx = crow_c + RowW'(1);
					end else if (byte_in != CH_ESC) ccol_nx = ccol_c + ColW'(1);
				end
				SQ_CSI: begin
					if (is_letter && byte_in == CH_H) begin
						crow_nx = RowW'(place(num0_q, seen_q[0], 8'(last_row)));
						ccol_nx = ColW'(place(num1_q, seen_q[1], 8'(last_col)));
					end else if (is_letter && byte_in == CH_J && num0_q <= 8'd3) begin
						st_nx = ST_FILL;
					end
				end
				default: ;
			endcase
		end
	end

	logic [AddrW-1:0] sweep_addr;
	assign sweep_addr = {wr_q, wc_q};

	always_comb begin
		req = '0;
		case (st_q)
			ST_CLEAR: begin
				req.wr_en   = 1'b1;
				req.wr_addr = clr_q;
				req.wr_data = {3'b000, CH_SPACE};
			end
			ST_IDLE: begin
				if (accept && operation == OP_READ) begin
					req.rd_en   = 1'b1;
					req.rd_addr = {read_row, read_column};
				end else if (accept && seq_q == SQ_NONE && byte_in != CH_ESC &&
					byte_in != CH_CR && byte_in != CH_LF) begin
					req.wr_en   = 1'b1;
					req.wr_addr = {crow_c, ccol_c};
					req.wr_data = {marks_q, byte_in};
				end
			end
			ST_SCRL: begin
				// read row+1, then write it to row in the next cycle
				req.rd_en   = !rd_pend_q;
				req.rd_addr = {wr_q + RowW'(1), wc_q};
				req.wr_en   = rd_pend_q;
				req.wr_addr = sweep_addr;
				req.wr_data = rd_data;
			end
			ST_FILL: begin
				req.wr_en   = 1'b1;
				req.wr_addr = sweep_addr;
				req.wr_data = {blank_m, CH_SPACE};
			end
			default: ;
		endcase
	end

	// outputs and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR; clr_q <= '0;
			rows_q <= 6'd24; cols_q <= 8'd80;
			crow_q <= '0; ccol_q <= '0; seq_q <= SQ_NONE; marks_q <= '0;
			num0_q <= '0; num1_q <= '0; nidx_q <= '0; seen_q <= '0;
			farg_q <= '0; tlen_q <= '0; out_valid <= 1'b0;
			rd_pend_q <= 1'b0; is_read_q <= 1'b0;
			wr_q <= '0; wc_q <= '0; er_q <= '0; ec_q <= '0;
			tvalid_q <= 1'b0; tbyte_q <= '0; tend_q <= 1'b0;
			cell_character <= '0; cell_bold <= 1'b0; cell_italic <= 1'b0;
			cell_underline <= 1'b0; cursor_row_out <= '0; cursor_column_out <= '0;
			title_valid <= 1'b0; title_byte <= '0; title_end <= 1'b0;
			in_sequence <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ROWS) rows_q <= cfg_data[5:0];
				else cols_q <= cfg_data;
			end
			if (st_q == ST_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AddrW'(1);
					if (&clr_q) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						st_q <= st_nx;
						crow_q <= crow_nx; ccol_q <= ccol_nx;
						is_read_q <= operation == OP_READ;
						tvalid_q <= title_take;
						tbyte_q <= title_take ? byte_in : 8'd0;
						tend_q <= title_stop;
						if (operation == OP_PUT) begin
							case (seq_q)
								SQ_NONE: begin
									if (byte_in == CH_ESC) seq_q <= SQ_START;
									else if ((byte_in == CH_LF || (byte_in != CH_CR &&
										ccol_c == last_col)) && crow_c == last_row) begin
										// scroll: copy rows up, then blank last row (a one-row area is only blanked)
										wr_q <= '0; wc_q <= '0; rd_pend_q <= 1'b0;
										er_q <= last_row; ec_q <= last_col;
									end
								end
								SQ_START: begin
									if (byte_in == CH_LBR) begin
										seq_q <= SQ_CSI; num0_q <= '0; num1_q <= '0;
										nidx_q <= '0; seen_q <= '0; farg_q <= '0;
									end else if (byte_in == CH_RBR) seq_q <= SQ_OSC;
									else seq_q <= SQ_NONE;
								end
								SQ_CSI: begin
									if (is_letter) begin
										seq_q <= SQ_NONE;
										if (byte_in == CH_J) begin
											if (num0_q == 8'd0) begin
												wr_q <= crow_c; wc_q <= ccol_c;
												er_q <= last_row; ec_q <= last_col;
											end else if (num0_q == 8'd1) begin
												wr_q <= '0; wc_q <= '0;
												er_q <= crow_c; ec_q <= ccol_c;
											end else if (num0_q == 8'd2 || num0_q == 8'd3) begin
												wr_q <= '0; wc_q <= '0;
												er_q <= last_row; ec_q <= last_col;
											end
										end else if (byte_in == CH_M) begin
											if (farg_q == CH_ZERO) marks_q <= '0;
											else if (farg_q == CH_ONE) marks_q <= marks_q | 3'b001;
											else if (farg_q == CH_THREE) marks_q <= marks_q | 3'b010;
											else if (farg_q == CH_FOUR) marks_q <= marks_q | 3'b100;
										end
									end else begin
										if (farg_q == 8'd0) farg_q <= byte_in;
										if (byte_in == CH_SEMI) begin
											if (nidx_q < 2'd2) nidx_q <= nidx_q + 2'd1;
										end else if (nidx_q < 2'd2) begin
											seen_q[nidx_q[0]] <= 1'b1;
											if (is_digit) begin
												if (nidx_q == 2'd0) num0_q <= sat10(num0_q, byte_in);
												else num1_q <= sat10(num1_q, byte_in);
											end
										end
									end
								end
								SQ_OSC: seq_q <= (byte_in == CH_ZERO) ? SQ_SEMI : SQ_NONE;
								SQ_SEMI: begin
									if (byte_in == CH_SEMI) begin
										seq_q <= SQ_TITLE; tlen_q <= '0;
									end else seq_q <= SQ_NONE;
								end
								SQ_TITLE: begin
									if (byte_in == CH_BEL) seq_q <= SQ_NONE;
									else if (tlen_q < 8'(TitleLimit)) tlen_q <= tlen_q + 8'd1;
								end
								default: seq_q <= SQ_NONE;
							endcase
						end
					end
				end
				ST_READ: st_q <= ST_OUT;
				ST_SCRL: begin
					rd_pend_q <= !rd_pend_q;
					if (rd_pend_q) begin
						if (wc_q == last_col) begin
							wc_q <= '0;
							if (wr_q + RowW'(1) == last_row) begin
								wr_q <= last_row; st_q <= ST_FILL;
							end else wr_q <= wr_q + RowW'(1);
						end else wc_q <= wc_q + ColW'(1);
					end
				end
				ST_FILL: begin
					if (wr_q == er_q && wc_q == ec_q) st_q <= ST_OUT;
					else if (wc_q == last_col) begin
						wc_q <= '0; wr_q <= wr_q + RowW'(1);
					end else wc_q <= wc_q + ColW'(1);
				end
				ST_OUT: begin
					// hold here while the previous result still waits
					if (!out_valid || out_ready) begin
						st_q <= ST_IDLE;
						if (is_read_q) begin
							cell_character <= rd_data[7:0];
							{cell_underline, cell_italic, cell_bold} <= rd_data[10:8];
						end else begin
							cell_character <= '0;
							{cell_underline, cell_italic, cell_bold} <= '0;
						end
						cursor_row_out <= crow_q; cursor_column_out <= ccol_q;
						title_valid <= tvalid_q; title_byte <= tbyte_q; title_end <= tend_q;
						in_sequence <= seq_q != SQ_NONE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/atte_checker.sv =====
// Port-level checker for the terminal engine, bound to the top level.
// Depends on atte_pkg.
module atte_checker
	import atte_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       title_valid,
	input logic       title_end,
	input logic [7:0] title_byte,
	input logic [7:0] cell_character
);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("second item taken");
	a_title_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(title_valid) && $stable(title_end) &&
		$stable(title_byte)) else $error("title changed while result waits");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cell_character))
		else $error("result dropped");
	a_title_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(title_valid && title_end)) else $error("title valid and end");
	a_title_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !title_valid |-> title_byte == 8'd0) else $error("stray title byte");

endmodule

bind ansi_text_terminal_engine_core atte_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.title_valid, .title_end, .title_byte, .cell_character
);
